// ===== hdl/bbc_pkg.sv =====
// Package for the bracket balance checker.
// Holds the character codes that the scanner recognises and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int unsigned OUT_BITS = 16;

    localparam logic [7:0] CH_BACKSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE       = 8'h22;
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;

    typedef struct packed {
        logic                balanced;
        logic                mismatch_found;
        logic [OUT_BITS-1:0] mismatch_pos;
        logic [OUT_BITS-1:0] paren_level;
        logic [OUT_BITS-1:0] square_level;
        logic [OUT_BITS-1:0] curly_level;
        logic                string_open;
    } bbc_result_t;

endpackage

// ===== hdl/bbc_scan.sv =====
// Scanner state for the bracket balance checker: string tracking, depth counters,
// byte index and first mismatch, with the end-of-text result formed from them.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_scan #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          char_code,
    input  logic                last_char,
    output bbc_pkg::bbc_result_t result
);

    localparam int unsigned           OUT_W    = bbc_pkg::OUT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

    logic                  in_str_reg, in_str_next;
    logic                  esc_reg, esc_next;
    logic [COUNT_BITS-1:0] paren_reg, paren_next;
    logic [COUNT_BITS-1:0] square_reg, square_next;
    logic [COUNT_BITS-1:0] curly_reg, curly_next;
    logic [COUNT_BITS-1:0] index_reg, index_next;
    logic                  mis_reg, mis_next;
    logic [COUNT_BITS-1:0] mis_idx_reg, mis_idx_next;

    always_comb begin
        in_str_next  = in_str_reg;
        esc_next     = esc_reg;
        paren_next   = paren_reg;
        square_next  = square_reg;
        curly_next   = curly_reg;
        mis_next     = mis_reg;
        mis_idx_next = mis_idx_reg;

        if (!mis_reg) begin
            if (in_str_reg) begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (char_code == bbc_pkg::CH_BACKSLASH) begin
                    esc_next = 1'b1;
                end else if (char_code == bbc_pkg::CH_QUOTE) begin
                    in_str_next = 1'b0;
                end
            end else begin
                case (char_code)
                    bbc_pkg::CH_QUOTE: begin
                        in_str_next = 1'b1;
                        esc_next    = 1'b0;
                    end
                    bbc_pkg::CH_OPEN_PAREN: begin
                        paren_next = (paren_reg == CNT_MAX) ? paren_reg : paren_reg + CNT_ONE;
                    end
                    bbc_pkg::CH_OPEN_SQUARE: begin
                        square_next = (square_reg == CNT_MAX) ? square_reg :
                                                                square_reg + CNT_ONE;
                    end
                    bbc_pkg::CH_OPEN_CURLY: begin
                        curly_next = (curly_reg == CNT_MAX) ? curly_reg : curly_reg + CNT_ONE;
                    end
                    bbc_pkg::CH_CLOSE_PAREN: begin
                        if (paren_reg == CNT_ZERO) begin
                            mis_next     = 1'b1;
                            mis_idx_next = index_reg;
                        end else begin
                            paren_next = paren_reg - CNT_ONE;
                        end
                    end
                    bbc_pkg::CH_CLOSE_SQUARE: begin
                        if (square_reg == CNT_ZERO) begin
                            mis_next     = 1'b1;
                            mis_idx_next = index_reg;
                        end else begin
                            square_next = square_reg - CNT_ONE;
                        end
                    end
                    bbc_pkg::CH_CLOSE_CURLY: begin
                        if (curly_reg == CNT_ZERO) begin
                            mis_next     = 1'b1;
                            mis_idx_next = index_reg;
                        end else begin
                            curly_next = curly_reg - CNT_ONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        index_next = (index_reg == CNT_MAX) ? index_reg : index_reg + CNT_ONE;

        result.balanced       = !mis_next && (paren_next == CNT_ZERO) &&
                                (square_next == CNT_ZERO) && (curly_next == CNT_ZERO) &&
                                !in_str_next;
        result.mismatch_found = mis_next;
        result.mismatch_pos   = mis_next ? OUT_W'(mis_idx_next) : '0;
        result.paren_level    = OUT_W'(paren_next);
        result.square_level   = OUT_W'(square_next);
        result.curly_level    = OUT_W'(curly_next);
        result.string_open    = in_str_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_char)) begin
            in_str_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            paren_reg   <= '0;
            square_reg  <= '0;
            curly_reg   <= '0;
            index_reg   <= '0;
            mis_reg     <= 1'b0;
            mis_idx_reg <= '0;
        end else if (step) begin
            in_str_reg  <= in_str_next;
            esc_reg     <= esc_next;
            paren_reg   <= paren_next;
            square_reg  <= square_next;
            curly_reg   <= curly_next;
            index_reg   <= index_next;
            mis_reg     <= mis_next;
            mis_idx_reg <= mis_idx_next;
        end
    end

endmodule

// ===== hdl/bracket_balance_checker_unit.sv =====
// Top level of the bracket balance checker: input register, scanner and result register.
// Depends on bbc_pkg and bbc_scan.
//
// Channel  Direction  Transfer carries
// s_       in         one byte of text in s_tdata, s_tlast on the final byte
// m_       out        one result per text, sent after the final byte
//
// One byte is taken per cycle unless a last byte waits for a stalled result; the scanner
// registers its counters on each byte taken. The result of a text is loaded into the
// output register as its last byte leaves the input register, provided the output register is free.
// Reset clears the scanner and both valid flags, so no partial text survives it.
// A stalled result only blocks the input when a further last byte is waiting for it.
`timescale 1ns / 1ps

module bracket_balance_checker_unit #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] balanced, [1] mismatch_found, [17:2] mismatch_pos,
                                   // [33:18] paren_level, [49:34] square_level,
                                   // [65:50] curly_level, [66] string_open, [71:67] zero
);

    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    bbc_pkg::bbc_result_t out_reg;
    bbc_pkg::bbc_result_t scan_result;
    logic                 out_free;
    logic                 consume;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    bbc_scan #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .result    (scan_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (consume && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume && in_last_reg) begin
            out_reg <= scan_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000,
                       out_reg.string_open,
                       out_reg.curly_level,
                       out_reg.square_level,
                       out_reg.paren_level,
                       out_reg.mismatch_pos,
                       out_reg.mismatch_found,
                       out_reg.balanced};

endmodule
